// ===== rtl/tut_pkg.sv =====
// Shared types and constants for the timer-driven UART transceiver.
`timescale 1ns / 1ps
package tut_pkg;

  // Field widths fixed by the word format
  localparam int BYTE_W       = 8;
  localparam int BIT_TICKS_W  = 16;
  localparam int HALF_TICKS_W = 15;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_BIT_TICKS      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HALF_BIT_TICKS = 2'd1;

  // Configuration reset values
  localparam logic [BIT_TICKS_W-1:0]  BIT_TICKS_RESET      = 16'd104;
  localparam logic [HALF_TICKS_W-1:0] HALF_BIT_TICKS_RESET = 15'd52;

  // Transmit request taken from one tick word
  typedef struct packed {
    logic              start;
    logic [BYTE_W-1:0] data;
  } tut_tx_req_t;

  // Transmitter status after a tick
  typedef struct packed {
    logic line;
    logic busy;
  } tut_tx_stat_t;

  // Receiver status after a tick
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } tut_rx_stat_t;

endpackage

// ===== rtl/tut_if.sv =====
// Handshake channels: tick words in, result words out, configuration writes.
`timescale 1ns / 1ps
interface tut_tick_if;
  import tut_pkg::*;
  logic              valid;
  logic              ready;
  logic              tx_start;
  logic [BYTE_W-1:0] tx_byte;
  logic              rx_level;
  modport source (output valid, tx_start, tx_byte, rx_level, input ready);
  modport sink   (input valid, tx_start, tx_byte, rx_level, output ready);
endinterface

interface tut_result_if;
  import tut_pkg::*;
  logic              valid;
  logic              ready;
  logic              tx_line;
  logic              tx_busy;
  logic              rx_valid;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, tx_line, tx_busy, rx_valid, rx_byte, input ready);
  modport sink   (input valid, tx_line, tx_busy, rx_valid, rx_byte, output ready);
endinterface

interface tut_cfg_if;
  import tut_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/timer_uart_transceiver_core.sv =====
// Top level: tick handshake, configuration registers and result register.
`timescale 1ns / 1ps
// A result word is presented the cycle after its tick word is accepted.
// Throughput: one tick word per cycle while results are read; the single result
// register frees as it is read. Tick ready drops only while a result waits unread
// with the sink stalled. Reset (synchronous, active high) idles both directions,
// line high, and loads bit_ticks = 104 and half_bit_ticks = 52.
module timer_uart_transceiver_core #(
  parameter int DATA_BITS   = 8,
  parameter int TIMER_WIDTH = 16
) (
  input logic         clk,
  input logic         rst,
  tut_tick_if.sink    tick,
  tut_result_if.source result,
  tut_cfg_if.sink     cfg
);
  import tut_pkg::*;

  logic [BIT_TICKS_W-1:0]  bit_ticks;
  logic [HALF_TICKS_W-1:0] half_bit_ticks;
  logic                    accept;
  tut_tx_req_t             tx_req;
  tut_tx_stat_t            tx_stat_next;
  tut_rx_stat_t            rx_stat_next;
  logic                    out_valid;
  tut_tx_stat_t            tx_stat;
  tut_rx_stat_t            rx_stat;

  // Configuration writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks      <= BIT_TICKS_RESET;
      half_bit_ticks <= HALF_BIT_TICKS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_BIT_TICKS:      bit_ticks      <= cfg.data;
        CFG_HALF_BIT_TICKS: half_bit_ticks <= cfg.data[HALF_TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Tick handshake
  assign tick.ready   = !out_valid || result.ready;
  assign accept       = tick.valid && tick.ready;
  assign tx_req.start = tick.tx_start;
  assign tx_req.data  = tick.tx_byte;

  tut_tx #(
    .DATA_BITS   (DATA_BITS),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_tx (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (tx_req),
    .bit_ticks (bit_ticks),
    .stat_next (tx_stat_next)
  );

  tut_rx #(
    .DATA_BITS   (DATA_BITS),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_rx (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .level          (tick.rx_level),
    .bit_ticks      (bit_ticks),
    .half_bit_ticks (half_bit_ticks),
    .stat_next      (rx_stat_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx_stat <= tx_stat_next;
      rx_stat <= rx_stat_next;
    end
  end

  assign result.valid    = out_valid;
  assign result.tx_line  = tx_stat.line;
  assign result.tx_busy  = tx_stat.busy;
  assign result.rx_valid = rx_stat.valid;
  assign result.rx_byte  = rx_stat.data;

  // Every accepted tick yields a result word on the next cycle
  a_result: assert property (@(posedge clk) disable iff (rst) accept |=> out_valid)
    else $error("accepted tick produced no result");

endmodule

// ===== rtl/tut_tx.sv =====
// Transmitter: frames one byte as start, data LSB first, stop after an idle bit period.
`timescale 1ns / 1ps
module tut_tx #(
  parameter int DATA_BITS   = 8,
  parameter int TIMER_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  tut_pkg::tut_tx_req_t                req,
  input  logic [tut_pkg::BIT_TICKS_W-1:0]     bit_ticks,
  output tut_pkg::tut_tx_stat_t               stat_next
);
  import tut_pkg::*;

  localparam int FRAME_BITS = DATA_BITS + 2;
  localparam int BL_W       = $clog2(FRAME_BITS + 1);

  logic [FRAME_BITS-1:0]  shift, shift_next;
  logic [BL_W-1:0]        bits_left, bits_left_next;
  logic [TIMER_WIDTH-1:0] timer, timer_next;
  logic                   active, active_next;
  logic                   level, level_next;

  logic [39:0]            ticks_ext;
  logic [TIMER_WIDTH-1:0] reload;
  logic [15:0]            byte_ext;
  logic                   timer_fire;

  // Period reload, masked to the timer width
  assign ticks_ext  = 40'(bit_ticks);
  assign reload     = ticks_ext[TIMER_WIDTH-1:0];
  assign byte_ext   = 16'(req.data);
  assign timer_fire = (timer[TIMER_WIDTH-1:1] == '0);

  // Next state for one tick
  always_comb begin
    shift_next     = shift;
    bits_left_next = bits_left;
    timer_next     = timer;
    active_next    = active;
    level_next     = level;
    if (active) begin
      if (timer_fire) begin
        timer_next = reload;
        if (bits_left == '0) begin
          active_next    = 1'b0;
          bits_left_next = BL_W'(FRAME_BITS);
        end else begin
          level_next     = shift[0];
          shift_next     = shift >> 1;
          bits_left_next = bits_left - 1'b1;
        end
      end else begin
        timer_next = timer - 1'b1;
      end
    end else if (req.start) begin
      shift_next     = {1'b1, byte_ext[DATA_BITS-1:0], 1'b0};
      bits_left_next = BL_W'(FRAME_BITS);
      timer_next     = reload;
      active_next    = 1'b1;
    end
  end

  assign stat_next.line = level_next;
  assign stat_next.busy = active_next;

  // State registers, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      shift     <= '0;
      bits_left <= BL_W'(FRAME_BITS);
      timer     <= '0;
      active    <= 1'b0;
      level     <= 1'b1;
    end else if (accept) begin
      shift     <= shift_next;
      bits_left <= bits_left_next;
      timer     <= timer_next;
      active    <= active_next;
      level     <= level_next;
    end
  end

  // Line sits high whenever no frame is in flight
  a_idle_high: assert property (@(posedge clk) disable iff (rst) !active |-> level)
    else $error("tx line low while idle");

  // A request on an idle tick starts a frame
  a_start: assert property (@(posedge clk) disable iff (rst)
    (accept && req.start && !active) |=> active)
    else $error("tx request not taken while idle");

  // Frame end restores the full bit count
  a_end: assert property (@(posedge clk) disable iff (rst)
    (accept && active && !active_next) |=> (bits_left == BL_W'(FRAME_BITS)) && level)
    else $error("tx frame end left bad state");

endmodule

// ===== rtl/tut_rx.sv =====
// Receiver: hunts a falling edge, samples mid-bit, assembles LSB first.
`timescale 1ns / 1ps
module tut_rx #(
  parameter int DATA_BITS   = 8,
  parameter int TIMER_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                level,
  input  logic [tut_pkg::BIT_TICKS_W-1:0]     bit_ticks,
  input  logic [tut_pkg::HALF_TICKS_W-1:0]    half_bit_ticks,
  output tut_pkg::tut_rx_stat_t               stat_next
);
  import tut_pkg::*;

  localparam int RT_W = TIMER_WIDTH + 1;
  localparam int BL_W = $clog2(DATA_BITS + 1);

  logic                 hunting, hunting_next;
  logic                 prev_level;
  logic [RT_W-1:0]      timer, timer_next;
  logic [DATA_BITS-1:0] shift, shift_next;
  logic [BL_W-1:0]      bits_left, bits_left_next, bits_dec;
  logic [DATA_BITS-1:0] hold, hold_next;
  logic                 done_next;

  logic [39:0]          first_ext, period_ext;
  logic [15:0]          hold_ext;
  logic                 timer_fire;

  // Reload values, masked to the receive timer width
  assign first_ext  = 40'(bit_ticks) + 40'(half_bit_ticks);
  assign period_ext = 40'(bit_ticks);
  assign timer_fire = (timer[RT_W-1:1] == '0);
  assign bits_dec   = (bits_left != '0) ? bits_left - 1'b1 : '0;

  // Next state for one tick
  always_comb begin
    hunting_next   = hunting;
    timer_next     = timer;
    shift_next     = shift;
    bits_left_next = bits_left;
    hold_next      = hold;
    done_next      = 1'b0;
    if (hunting) begin
      if (prev_level && !level) begin
        hunting_next = 1'b0;
        timer_next   = first_ext[RT_W-1:0];
      end
    end else if (timer_fire) begin
      shift_next = {level, shift[DATA_BITS-1:1]};
      if (bits_dec == '0) begin
        hold_next      = shift_next;
        bits_left_next = BL_W'(DATA_BITS);
        hunting_next   = 1'b1;
        done_next      = 1'b1;
      end else begin
        bits_left_next = bits_dec;
        timer_next     = period_ext[RT_W-1:0];
      end
    end else begin
      timer_next = timer - 1'b1;
    end
  end

  assign hold_ext       = 16'(hold_next);
  assign stat_next.valid = done_next;
  assign stat_next.data  = hold_ext[BYTE_W-1:0];

  // State registers, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      hunting    <= 1'b1;
      prev_level <= 1'b1;
      timer      <= '0;
      shift      <= '0;
      bits_left  <= BL_W'(DATA_BITS);
      hold       <= '0;
    end else if (accept) begin
      hunting    <= hunting_next;
      prev_level <= level;
      timer      <= timer_next;
      shift      <= shift_next;
      bits_left  <= bits_left_next;
      hold       <= hold_next;
    end
  end

  // A completed byte sends the receiver back to hunting with a full count
  a_done: assert property (@(posedge clk) disable iff (rst)
    (accept && done_next) |=> hunting && (bits_left == BL_W'(DATA_BITS)))
    else $error("rx did not rearm after byte");

endmodule

// ===== tb/tb.sv =====
// Testbench for timer_uart_transceiver_core: directed and random tick words against a predictor.
`timescale 1ns / 1ps
module tb;
  import tut_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int FRAME_BITS     = BYTE_W + 2;
  localparam int PHASE_TICKS    = 450;
  localparam int EXTREME_TICKS  = 40;
  localparam int DRAIN_CYCLES   = 4;
  localparam int END_CYCLES     = 8;
  localparam int HOLDOFF_CYCLES = 600;
  localparam int WATCHDOG_LIMIT = 5000;

  // Index that maps to no register; writes to it must be dropped
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  typedef struct packed {
    tut_tx_stat_t tx;
    tut_rx_stat_t rx;
  } uart_status_t;

  logic clk = 1'b0;
  logic rst;

  tut_tick_if   tick_if ();
  tut_result_if result_if ();
  tut_cfg_if    cfg_if ();

  timer_uart_transceiver_core u_top (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Predicted register contents
  logic [BIT_TICKS_W-1:0]  cfg_bit_ticks;
  logic [HALF_TICKS_W-1:0] cfg_half_ticks;

  // Predicted transmitter and receiver state
  logic [FRAME_BITS-1:0]  tx_frame_sr;
  logic [3:0]             tx_bits_to_go;
  logic [BIT_TICKS_W-1:0] tx_period_cnt;
  logic                   tx_sending;
  logic                   tx_line_lvl;
  logic                   rx_waiting_edge;
  logic                   rx_last_lvl;
  logic [BIT_TICKS_W:0]   rx_period_cnt;
  logic [BYTE_W-1:0]      rx_data_sr;
  logic [3:0]             rx_bits_to_go;
  logic [BYTE_W-1:0]      rx_last_byte;

  uart_status_t      status_q[$];
  logic              rx_wave_q[$];
  logic [BYTE_W-1:0] rx_directed_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned holdoff_req;
  int unsigned holdoff_left;
  int unsigned quiet_cycles;
  int unsigned error_count;
  int unsigned tick_count;
  int unsigned tx_frame_count;
  int unsigned rx_byte_count;
  int unsigned reg_write_count;

  // One tick through the transceiver; returns the status seen after it
  function automatic uart_status_t uart_tick_status(input logic start,
                                                    input logic [BYTE_W-1:0] data,
                                                    input logic level);
    uart_status_t s;
    logic         done;
    done = 1'b0;
    // transmitter: busy is judged before this tick's request
    if (tx_sending) begin
      if (tx_period_cnt <= 1) begin
        tx_period_cnt = cfg_bit_ticks;
        if (tx_bits_to_go == 0) begin
          tx_sending    = 1'b0;
          tx_bits_to_go = 4'(FRAME_BITS);
        end else begin
          tx_line_lvl   = tx_frame_sr[0];
          tx_frame_sr   = tx_frame_sr >> 1;
          tx_bits_to_go = tx_bits_to_go - 1'b1;
        end
      end else begin
        tx_period_cnt = tx_period_cnt - 1'b1;
      end
    end else if (start) begin
      tx_frame_sr    = {1'b1, data, 1'b0};
      tx_bits_to_go  = 4'(FRAME_BITS);
      tx_period_cnt  = cfg_bit_ticks;
      tx_sending     = 1'b1;
      tx_frame_count++;
    end
    // receiver: edges are ignored until the last data bit is sampled
    if (rx_waiting_edge) begin
      if (rx_last_lvl && !level) begin
        rx_waiting_edge = 1'b0;
        rx_period_cnt   = {1'b0, cfg_bit_ticks} + {2'b00, cfg_half_ticks};
      end
    end else if (rx_period_cnt <= 1) begin
      rx_data_sr = {level, rx_data_sr[BYTE_W-1:1]};
      if (rx_bits_to_go > 0) rx_bits_to_go = rx_bits_to_go - 1'b1;
      if (rx_bits_to_go == 0) begin
        rx_last_byte    = rx_data_sr;
        rx_bits_to_go   = 4'(BYTE_W);
        rx_waiting_edge = 1'b1;
        done            = 1'b1;
        rx_byte_count++;
      end else begin
        rx_period_cnt = {1'b0, cfg_bit_ticks};
      end
    end else begin
      rx_period_cnt = rx_period_cnt - 1'b1;
    end
    rx_last_lvl = level;
    s.tx.line  = tx_line_lvl;
    s.tx.busy  = tx_sending;
    s.rx.valid = done;
    s.rx.data  = rx_last_byte;
    return s;
  endfunction

  // Append the next stretch of receive-line levels: mostly clean frames at the
  // current bit period, some cut-short frames, glitches and noise; only noise above 64 ticks
  function automatic void plan_rx_traffic();
    int unsigned       bt;
    int unsigned       kind;
    int unsigned       nbits;
    logic [BYTE_W-1:0] data;
    bt   = cfg_bit_ticks;
    kind = $urandom_range(9);
    data = 8'($urandom_range(255));
    if (bt > 64) begin
      kind = 9;
    end else if (rx_directed_q.size() != 0) begin
      kind = 0;
      data = rx_directed_q.pop_front();
    end
    if (kind == 9) begin
      repeat ($urandom_range(1, 20)) rx_wave_q.push_back(1'($urandom_range(1)));
    end else if (kind == 8) begin
      // false start: short low pulse
      rx_wave_q.push_back(1'b1);
      repeat ($urandom_range(1, bt)) rx_wave_q.push_back(1'b0);
    end else begin
      // cut-short frames let the next start edge land mid-sampling
      nbits = (kind == 7) ? $urandom_range(7) : BYTE_W + 1;
      repeat ($urandom_range(1, 2 * bt)) rx_wave_q.push_back(1'b1);
      repeat (bt) rx_wave_q.push_back(1'b0);
      for (int i = 0; i < nbits; i++)
        repeat (bt) rx_wave_q.push_back((i < BYTE_W) ? data[i] : 1'b1);
    end
  endfunction

  function automatic logic next_rx_level();
    if (rx_wave_q.size() == 0) plan_rx_traffic();
    return rx_wave_q.pop_front();
  endfunction

  // Offer one tick word; called and returns at a falling edge
  task automatic send_tick(input logic start, input logic [BYTE_W-1:0] data,
                           input logic level);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_if.valid <= 1'b0;
      @(negedge clk);
    end
    tick_if.valid    <= 1'b1;
    tick_if.tx_start <= start;
    tick_if.tx_byte  <= data;
    tick_if.rx_level <= level;
    do @(posedge clk); while (!tick_if.ready);
    status_q.push_back(uart_tick_status(start, data, level));
    tick_count++;
    @(negedge clk);
  endtask

  // Let every expected word arrive, then let the core idle before returning
  task automatic drain();
    tick_if.valid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (index)
      CFG_BIT_TICKS:      cfg_bit_ticks  = value;
      CFG_HALF_BIT_TICKS: cfg_half_ticks = value[HALF_TICKS_W-1:0];
      default: ;
    endcase
    reg_write_count++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count)
      send_tick($urandom_range(3) == 0, 8'($urandom_range(255)), next_rx_level());
  endtask

  // Reset periods: a frame and a receive edge at 104 / 52 ticks
  task automatic test_reset_values();
    send_tick(1'b1, 8'h81, 1'b1);
    send_tick(1'b1, 8'h3C, 1'b0);
    repeat (4) send_tick(1'b0, 8'($urandom_range(255)), 1'b0);
  endtask

  // Shortest periods written while the reset-rate frame is still running;
  // requests while busy and edges in the middle of sampling
  task automatic test_directed();
    write_reg(CFG_BIT_TICKS, 16'd4);
    write_reg(CFG_HALF_BIT_TICKS, 16'd2);
    for (int i = 0; i < 20; i++)
      send_tick(i % 6 == 0, (i % 2) ? 8'hFF : 8'h00,
                (i == 0) ? 1'b1 : (i < 5) ? 1'b0 : i[1]);
  endtask

  // Random traffic under each idling pattern, new periods in each phase
  task automatic test_idle_phases();
    int unsigned send_pct[4] = '{0, 53, 0, 27};
    int unsigned recv_pct[4] = '{0, 0, 53, 27};
    int unsigned bt;
    for (int p = 0; p < 4; p++) begin
      bt = (p == 0) ? 4 : $urandom_range(4, 9);
      write_reg(CFG_BIT_TICKS, 16'(bt));
      write_reg(CFG_HALF_BIT_TICKS, 16'((p == 0) ? 2 : $urandom_range(2, bt)));
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      test_random_traffic(PHASE_TICKS);
    end
  endtask

  // Largest periods: the 17-bit first-sample count and the full 16-bit bit
  // count start from idle, then the periods are cut back while both run
  task automatic test_timer_extremes();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // let both sides finish at the current short period
    while (tx_sending || !rx_waiting_edge) send_tick(1'b0, 8'h00, 1'b1);
    write_reg(CFG_BIT_TICKS, 16'hFFFF);
    write_reg(CFG_HALF_BIT_TICKS, 16'h7FFF);
    send_tick(1'b1, 8'($urandom_range(255)), 1'b1);
    send_tick(1'b0, 8'h00, 1'b0);
    repeat (EXTREME_TICKS) send_tick(1'b1, 8'h00, 1'($urandom_range(1)));
    write_reg(CFG_BIT_TICKS, 16'd4);
    write_reg(CFG_HALF_BIT_TICKS, 16'd2);
    write_reg(CFG_UNUSED_INDEX, 16'hFFFF);
    repeat (EXTREME_TICKS) send_tick(1'b0, 8'h00, 1'($urandom_range(1)));
  endtask

  // Long receiver hold-off while ticks keep coming, so the input backs up
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(CFG_BIT_TICKS, 16'd5);
    write_reg(CFG_HALF_BIT_TICKS, 16'd3);
    holdoff_req = HOLDOFF_CYCLES;
    test_random_traffic(60);
  endtask

  // Result ready: random stalls, or a counted hold-off when requested
  always @(negedge clk) begin
    if (holdoff_req != 0) begin
      holdoff_left = holdoff_req;
      holdoff_req  = 0;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic compare_field(input string field, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      error_count++;
    end
  endtask

  // Check each result word against the oldest prediction
  always @(posedge clk) begin : check_results
    uart_status_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (status_q.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual line %b busy %b valid %b byte %0h",
                 $time, result_if.tx_line, result_if.tx_busy, result_if.rx_valid,
                 result_if.rx_byte);
        error_count++;
      end else begin
        want = status_q.pop_front();
        compare_field("tx_line", 8'(want.tx.line), 8'(result_if.tx_line));
        compare_field("tx_busy", 8'(want.tx.busy), 8'(result_if.tx_busy));
        compare_field("rx_valid", 8'(want.rx.valid), 8'(result_if.rx_valid));
        compare_field("rx_byte", want.rx.data, result_if.rx_byte);
      end
    end
  end

  // Watchdog: too long with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (tick_if.valid && tick_if.ready) || (result_if.valid && result_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, status_q.size());
      $display("timer_uart_transceiver_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst              = 1'b1;
    tick_if.valid    = 1'b0;
    tick_if.tx_start = 1'b0;
    tick_if.tx_byte  = '0;
    tick_if.rx_level = 1'b1;
    result_if.ready  = 1'b1;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_BIT_TICKS;
    cfg_if.data      = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    holdoff_req      = 0;
    holdoff_left     = 0;
    quiet_cycles     = 0;
    error_count      = 0;
    tick_count       = 0;
    tx_frame_count   = 0;
    rx_byte_count    = 0;
    reg_write_count  = 0;
    // predicted state after reset
    cfg_bit_ticks    = BIT_TICKS_RESET;
    cfg_half_ticks   = HALF_BIT_TICKS_RESET;
    tx_frame_sr      = '0;
    tx_bits_to_go    = 4'(FRAME_BITS);
    tx_period_cnt    = '0;
    tx_sending       = 1'b0;
    tx_line_lvl      = 1'b1;
    rx_waiting_edge  = 1'b1;
    rx_last_lvl      = 1'b1;
    rx_period_cnt    = '0;
    rx_data_sr       = '0;
    rx_bits_to_go    = 4'(BYTE_W);
    rx_last_byte     = '0;
    rx_directed_q.push_back(8'h00);
    rx_directed_q.push_back(8'hFF);

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_values();
    test_directed();
    test_idle_phases();
    test_backpressure();
    test_timer_extremes();

    // wait out the last results
    tick_if.valid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (END_CYCLES) @(negedge clk);

    $display("Ran %0d tick words: %0d frames sent, %0d bytes received, %0d register writes",
             tick_count, tx_frame_count, rx_byte_count, reg_write_count);
    $display("Periods 4..65535 ticks, idling none/sender/receiver/both, %0d-cycle hold-off",
             HOLDOFF_CYCLES);
    if (error_count == 0) begin
      $display("timer_uart_transceiver_core: match");
    end else begin
      $display("timer_uart_transceiver_core: mismatch");
    end
    $finish;
  end

endmodule
